// File: src/chc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

    // Datapath sizes
    localparam int CORDIC_STEPS      = 32;
    localparam int DATA_W            = 35;   // 2^31 magnitude, times gain and sqrt(2)
    localparam int ANG_W             = 32;   // binary angle, one turn is 2^32
    localparam int OUT_W             = 16;
    localparam int FRAC_BITS_DEFAULT = 7;
    localparam int PROD_W            = 42;   // 33-bit heading times 360

    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    // One item as it moves through the rotation stages
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [ANG_W-1:0]         ang;
        logic                     hold;   // angle exact already, no rotation
    } cordic_t;

    // atan(2^-i) in binary angle
    function automatic logic [ANG_W-1:0] atab(input int i);
        logic [ANG_W-1:0] t;
        case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            24: t = 32'h00000029;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000003;
            29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: src/chc_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Joins the register bytes, folds the left half plane onto the right one.
module chc_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      x_high,
    input  wire logic [7:0]      x_low,
    input  wire logic [7:0]      y_high,
    input  wire logic [7:0]      y_low,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output chc_pkg::cordic_t     out_data
);

    logic               valid_reg;
    chc_pkg::cordic_t   data_reg;
    chc_pkg::cordic_t   data_next;
    logic signed [15:0] x16;
    logic signed [15:0] y16;
    logic signed [chc_pkg::DATA_W-1:0] xs;
    logic signed [chc_pkg::DATA_W-1:0] ys;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Scale by 2^16, negate when x is negative
    always_comb begin
        x16 = {x_high, x_low};
        y16 = {y_high, y_low};
        xs  = chc_pkg::DATA_W'(x16) <<< 16;
        ys  = chc_pkg::DATA_W'(y16) <<< 16;
        if (x16[15]) begin
            data_next.x   = -xs;
            data_next.y   = -ys;
            data_next.ang = chc_pkg::HALF_TURN;
        end else begin
            data_next.x   = xs;
            data_next.y   = ys;
            data_next.ang = '0;
        end
        // y zero: angle is exactly 0 or a half turn
        data_next.hold = (y16 == 16'sd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: src/chc_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// One vectoring step, rotation by atan(2^-STEP).
module chc_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire chc_pkg::cordic_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output chc_pkg::cordic_t        out_data
);

    localparam logic [chc_pkg::ANG_W-1:0] ANGLE = chc_pkg::atab(STEP);

    logic             valid_reg;
    chc_pkg::cordic_t data_reg;
    chc_pkg::cordic_t data_next;
    logic signed [chc_pkg::DATA_W-1:0] xs;
    logic signed [chc_pkg::DATA_W-1:0] ys;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Floor shifts, rotate toward y = 0
    always_comb begin
        xs        = in_data.x >>> STEP;
        ys        = in_data.y >>> STEP;
        data_next = in_data;
        if (!in_data.hold) begin
            if (!in_data.y[chc_pkg::DATA_W-1]) begin
                data_next.x   = in_data.x + ys;
                data_next.y   = in_data.y - xs;
                data_next.ang = in_data.ang + ANGLE;
            end else begin
                data_next.x   = in_data.x - ys;
                data_next.y   = in_data.y + xs;
                data_next.ang = in_data.ang - ANGLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: src/chc_scale.sv
`timescale 1ns / 1ps
`default_nettype none

// Heading = one turn minus angle, scaled to degrees: multiply, then round and saturate.
module chc_scale #(
    parameter int FRAC_BITS = chc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [chc_pkg::ANG_W-1:0]   in_ang,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [chc_pkg::OUT_W-1:0]        heading
);

    localparam int WIDE_W = chc_pkg::PROD_W + FRAC_BITS;

    logic                          prod_valid_reg;
    logic [chc_pkg::PROD_W-1:0]    prod_reg;
    logic [chc_pkg::PROD_W-1:0]    prod_next;
    logic [chc_pkg::ANG_W:0]       h;
    logic                          out_valid_reg;
    logic [chc_pkg::OUT_W-1:0]     heading_reg;
    logic [chc_pkg::OUT_W-1:0]     heading_next;
    logic [WIDE_W-1:0]             wide;
    logic [31:0]                   q;
    logic                          prod_ready;

    assign prod_ready = !out_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign out_valid  = out_valid_reg;
    assign heading    = heading_reg;

    // Negate the angle; zero reads as a full turn
    always_comb begin
        h = {1'b0, (chc_pkg::ANG_W)'(0) - in_ang};
        if (in_ang == '0) begin
            h = {1'b1, {chc_pkg::ANG_W{1'b0}}};
        end
        prod_next = chc_pkg::PROD_W'(h) * chc_pkg::PROD_W'(360);
    end

    // Round half up, saturate to the output width
    always_comb begin
        wide = (WIDE_W'(prod_reg) << FRAC_BITS) + WIDE_W'(64'h8000_0000);
        q    = 32'(wide >> 32);
        if (q > 32'h0000_FFFF) begin
            heading_next = '1;
        end else begin
            heading_next = q[chc_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg) begin
            heading_reg <= heading_next;
        end
    end

endmodule

`default_nettype wire

// File: src/compass_heading_from_magnetometer_core.sv
// Channel | Ports                                   | Beat
// --------+-----------------------------------------+---------------------------------
// input   | s_valid s_ready s_x_high s_x_low        | one X/Y sample, register bytes
//         | s_y_high s_y_low                        |
// result  | m_valid m_ready m_heading_deg           | one heading, unsigned Q(16-F).F
//
// One sample per cycle sustained while m_ready is high. Stages: input stage,
// 32 CORDIC stages (one vectoring step each), multiply stage and rounding stage.
// Reset clears the valid bits of every stage; payload registers hold.
// Each stage has its own valid bit and loads when it is empty or its
// successor takes its beat, so bubbles close up under a stall and a stalled
// result does not block new samples until the pipeline is full.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_from_magnetometer_core #(
    parameter int FRAC_BITS = chc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_x_high,
    input  wire logic [7:0]                s_x_low,
    input  wire logic [7:0]                s_y_high,
    input  wire logic [7:0]                s_y_low,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [chc_pkg::OUT_W-1:0]      m_heading_deg
);

    localparam int N = chc_pkg::CORDIC_STEPS;

    logic             valid_w [N+1];
    logic             ready_w [N+1];
    chc_pkg::cordic_t data_w  [N+1];

    // Input stage
    chc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_high    (s_x_high),
        .x_low     (s_x_low),
        .y_high    (s_y_high),
        .y_low     (s_y_low),
        .out_valid (valid_w[0]),
        .out_ready (ready_w[0]),
        .out_data  (data_w[0])
    );

    // Rotation stages
    for (genvar i = 0; i < N; i++) begin : g_step
        chc_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_data   (data_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_data  (data_w[i+1])
        );
    end

    // Degrees and rounding
    chc_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_w[N]),
        .in_ready  (ready_w[N]),
        .in_ang    (data_w[N].ang),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .heading   (m_heading_deg)
    );

endmodule

`default_nettype wire

// File: src/chc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module chc_checker #(
    parameter int FRAC_BITS = chc_pkg::FRAC_BITS_DEFAULT
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [chc_pkg::OUT_W-1:0] m_heading_deg
);

    localparam int DEPTH = chc_pkg::CORDIC_STEPS + 3;
    localparam longint FULL = 360 * (longint'(1) << FRAC_BITS);
    localparam logic [chc_pkg::OUT_W-1:0] MAX_OUT =
        (FULL > 65535) ? 16'hFFFF : chc_pkg::OUT_W'(FULL);

    logic [7:0] inflight_reg;
    logic [7:0] inflight_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Beats accepted but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat) begin
            inflight_next = inflight_reg + 8'd1;
        end else if (out_beat && !in_beat) begin
            inflight_next = inflight_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading_deg))
        else $error("result changed while stalled");

    // No result without a sample behind it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 8'd0)
        else $error("result without an accepted sample");

    // Occupancy never exceeds the pipeline depth
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 8'(DEPTH))
        else $error("more samples in flight than stages");

    // Heading never above a full turn
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_heading_deg <= MAX_OUT)
        else $error("heading out of range");

endmodule

bind compass_heading_from_magnetometer_core chc_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_chc_checker (.*);

`default_nettype wire

// File: verif/tb_compass_heading_from_magnetometer_core.sv
`timescale 1ns / 1ps

module tb_compass_heading_from_magnetometer_core;

    localparam int FRAC_BITS   = 7;
    localparam int LATENCY     = 35;
    localparam int N_RANDOM    = 900;
    localparam int HOLD_CYCLES = 200;
    localparam int CLK_HALF    = 6;
    localparam longint TIMEOUT_NS = 200_000 * 2 * CLK_HALF;

    localparam logic [31:0] HALF_REV = 32'h8000_0000;

    // Predicts headings of accepted samples and checks delivered ones
    class heading_scoreboard;
        typedef struct {
            logic signed [15:0] x;
            logic signed [15:0] y;
            logic [15:0]        heading;
        } pending_t;

        pending_t pending_q[$];
        int       frac_bits;
        int       errors;
        int       n_sent;
        int       n_checked;
        int       n_on_axis;
        int       n_north;

        function new(int frac);
            frac_bits = frac;
        endfunction

        // atan(2^-i) as a fraction of one turn, 2^32 units
        function logic [31:0] atan_step(int i);
            logic [31:0] t;
            case (i)
                0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
                2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
                4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
                6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
                8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
                10: t = 32'h000A2F98;  11: t = 32'h000517CC;
                12: t = 32'h00028BE6;  13: t = 32'h000145F3;
                14: t = 32'h0000A2F9;  15: t = 32'h0000517D;
                16: t = 32'h000028BE;  17: t = 32'h0000145F;
                18: t = 32'h00000A30;  19: t = 32'h00000518;
                20: t = 32'h0000028C;  21: t = 32'h00000146;
                22: t = 32'h000000A3;  23: t = 32'h00000051;
                24: t = 32'h00000029;  25: t = 32'h00000014;
                26: t = 32'h0000000A;  27: t = 32'h00000005;
                28: t = 32'h00000003;  29: t = 32'h00000001;
                30: t = 32'h00000001;
                default: t = 32'h00000000;
            endcase
            return t;
        endfunction

        // Heading in fixed point for one X/Y sample
        function logic [15:0] heading_of(logic signed [15:0] x, logic signed [15:0] y);
            longint      xv;
            longint      yv;
            longint      dx;
            longint      dy;
            logic [31:0] ang;
            logic [63:0] turn;
            logic [63:0] q;
            xv  = x;
            yv  = y;
            ang = '0;
            if (yv == 0) begin
                // on the X axis the angle is exact
                ang = (xv >= 0) ? 32'd0 : HALF_REV;
            end else begin
                xv = xv * 65536;
                yv = yv * 65536;
                if (xv < 0) begin
                    xv  = -xv;
                    yv  = -yv;
                    ang = HALF_REV;
                end
                // vectoring: drive y to zero, accumulate the angle
                for (int i = 0; i < 32; i++) begin
                    dx = xv >>> i;
                    dy = yv >>> i;
                    if (yv >= 0) begin
                        xv  = xv + dy;
                        yv  = yv - dx;
                        ang = ang + atan_step(i);
                    end else begin
                        xv  = xv - dy;
                        yv  = yv + dx;
                        ang = ang - atan_step(i);
                    end
                end
            end
            // heading = full turn minus angle; zero angle reads as a full turn
            turn = {32'd0, 32'd0 - ang};
            if (turn == 0)
                turn = 64'h1_0000_0000;
            q = (((turn * 64'd360) << frac_bits) + 64'h8000_0000) >> 32;
            if (q > 64'hFFFF)
                q = 64'hFFFF;
            return q[15:0];
        endfunction

        function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
            pending_t p;
            p.x       = x;
            p.y       = y;
            p.heading = heading_of(x, y);
            pending_q.push_back(p);
            n_sent++;
            if (y == 0)
                n_on_axis++;
            if (p.heading == 0 || p.heading == (16'd360 << frac_bits))
                n_north++;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_heading(logic [15:0] got);
            pending_t p;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("heading %0d with no sample outstanding", got));
                return;
            end
            p = pending_q.pop_front();
            n_checked++;
            if (got !== p.heading)
                report_mismatch($sformatf("x=%0d y=%0d: heading %0d, want %0d",
                                          p.x, p.y, got, p.heading));
        endtask

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_x_high      = '0;
    logic [7:0]  s_x_low       = '0;
    logic [7:0]  s_y_high      = '0;
    logic [7:0]  s_y_low       = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [15:0] m_heading_deg;

    heading_scoreboard sb;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;

    compass_heading_from_magnetometer_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_x_high     (s_x_high),
        .s_x_low      (s_x_low),
        .s_y_high     (s_y_high),
        .s_y_low      (s_y_low),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_heading_deg(m_heading_deg)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Result side: check each beat, then pick next ready (or sit in a long hold)
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_heading(m_heading_deg);
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one sample, with random idle cycles ahead of it
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_x_high <= x[15:8];
        s_x_low  <= x[7:0];
        s_y_high <= y[15:8];
        s_y_low  <= y[7:0];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_sample(x, y);
    endtask

    // Random value of a chosen flavor: full range, near zero, or zero
    function automatic logic [15:0] rand_axis(int kind);
        logic [15:0] v;
        case (kind)
            0:       v = 16'($urandom);
            1:       v = 16'($signed($urandom_range(16)) - 8);
            default: v = '0;
        endcase
        return v;
    endfunction

    task automatic send_random();
        int          pick;
        logic [15:0] x;
        logic [15:0] y;
        pick = $urandom_range(99);
        if (pick < 50) begin
            x = rand_axis(0);  y = rand_axis(0);
        end else if (pick < 65) begin
            x = rand_axis(1);  y = rand_axis(1);
        end else if (pick < 75) begin
            x = rand_axis(0);  y = rand_axis(2);
        end else if (pick < 85) begin
            x = rand_axis(2);  y = rand_axis(0);
        end else if (pick < 93) begin
            x = rand_axis(0);  y = rand_axis(1);
        end else begin
            x = rand_axis(1);  y = rand_axis(0);
        end
        send_sample(x, y);
    endtask

    initial begin
        sb = new(FRAC_BITS);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: axes, both zero, extremes, diagonals, headings near zero
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_sample(16'sd0,      16'sd0);
        send_sample(16'sd1,      16'sd0);
        send_sample(16'sd32767,  16'sd0);
        send_sample(-16'sd1,     16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0,      16'sd1);
        send_sample(16'sd0,      -16'sd1);
        send_sample(16'sd0,      16'sd32767);
        send_sample(16'sd0,      -16'sd32768);
        send_sample(16'sd1,      16'sd1);
        send_sample(-16'sd1,     16'sd1);
        send_sample(-16'sd1,     -16'sd1);
        send_sample(16'sd1,      -16'sd1);
        send_sample(16'sd32767,  16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767,  -16'sd32768);
        send_sample(16'sd32767,  -16'sd1);
        send_sample(16'sd32767,  -16'sd2);
        send_sample(16'sd32767,  -16'sd3);
        send_sample(16'sd32767,  16'sd1);
        send_sample(-16'sd32768, 16'sd1);
        send_sample(-16'sd32768, -16'sd1);
        send_sample(16'sd12345,  -16'sd6789);

        // random, three idle profiles; long result-side hold in the last one
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 0) begin
                send_idle_pct = 38;
                recv_idle_pct = 58;
            end else if (n == N_RANDOM / 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 38;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req <= 1'b1;
            end
            send_random();
        end
        s_valid <= 1'b0;

        // drain, then watch for stray beats
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Covered %0d samples (%0d on the X axis, %0d headings at 0 or full turn),",
                 sb.n_sent, sb.n_on_axis, sb.n_north);
        $display("%0d headings checked across three stall profiles and one long hold.",
                 sb.n_checked);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: results still outstanding");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
src/chc_pkg.sv
src/chc_front.sv
src/chc_cordic_stage.sv
src/chc_scale.sv
src/compass_heading_from_magnetometer_core.sv
src/chc_checker.sv
verif/tb_compass_heading_from_magnetometer_core.sv
